// ----- rtl/dpm_pkg.sv -----
package dpm_pkg;

    localparam int KIND_LOAD = 0;
    localparam int KIND_RUN  = 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_RELAX,
        S_DONE
    } t_state;

endpackage

// ----- rtl/dpm_ram.sv -----
module dpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dpm_front.sv -----
// Two-entry input queue.
module dpm_front #(
    parameter int W = 31
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_q [2];
    logic         r_rd;
    logic         r_wr;
    logic [1:0]   r_cnt;
    logic         push;
    logic         pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- rtl/dense_prim_mst_weight_core.sv -----
// Prim spanning tree over a dense matrix. The back end takes load beats only
// while idle. A run over n nodes (node_count clamped to MAX_NODES) has an init
// pass over row 0, then n-1 rounds of a scan over the distance RAM and a relax
// walk over the chosen matrix row. Each pass issues n reads, one per cycle, and
// then drains the registered read. A run with n below 2 goes straight to the
// result. A run is not started while a result still waits. A two-entry input
// queue lets loads arrive while the back end works. The total appears on a
// registered output and saturates at 23 bits.
module dense_prim_mst_weight_core #(
    parameter int MAX_NODES   = 128,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [6:0]  i_row,
    input  logic [6:0]  i_col,
    input  logic [15:0] i_weight,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [22:0] o_total_weight
);

    localparam int NB = $clog2(MAX_NODES);
    localparam int CB = NB + 1;
    localparam int AB = 2 * NB;
    localparam int WB = WEIGHT_BITS;
    localparam int QW = 31;
    localparam logic [23:0] TMAX = 24'h7FFFFF;

    logic [7:0] r_node_count;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_node_count <= 8'd0;
        else if (i_cfg_we) r_node_count <= i_cfg_wdata;
    end

    logic          q_valid;
    logic          q_ready;
    logic [QW-1:0] q_data;
    dpm_front #(.W(QW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_data({i_kind, i_row, i_col, i_weight}),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_data)
    );

    logic        q_kind;
    logic [6:0]  q_row, q_col;
    logic [15:0] q_w;
    assign {q_kind, q_row, q_col, q_w} = q_data;

    dpm_pkg::t_state r_state, n_state;
    logic [CB-1:0] r_n, r_j, r_round;
    logic [NB-1:0] r_pick;
    logic [WB-1:0] r_pdist;
    logic          r_found;
    logic [23:0]   r_total;
    logic          r_ovalid;
    logic [22:0]   r_out;
    logic          r_rv;
    logic [NB-1:0] r_rj;

    logic          mem_we;
    logic [AB-1:0] mem_wa, mem_ra;
    logic [WB-1:0] mem_rd;
    logic [WB-1:0] wmask;

    // distance RAM entry: {in_tree, best distance}
    logic          d_we;
    logic [NB-1:0] d_wa;
    logic [WB:0]   d_wd;
    logic [WB:0]   d_rd;
    logic          d_in;
    logic [WB-1:0] d_dist;
    assign {d_in, d_dist} = d_rd;

    assign wmask  = WB'(q_w);
    assign mem_we = (r_state == dpm_pkg::S_IDLE) && q_valid && (q_kind == 1'(dpm_pkg::KIND_LOAD))
                    && ({25'd0, q_row} < MAX_NODES) && ({25'd0, q_col} < MAX_NODES);
    assign mem_wa = {NB'(q_row), NB'(q_col)};

    dpm_ram #(.WIDTH(WB), .DEPTH(1 << AB)) u_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_wa), .i_wdata(wmask),
        .i_raddr(mem_ra), .o_rdata(mem_rd)
    );

    dpm_ram #(.WIDTH(WB + 1), .DEPTH(MAX_NODES)) u_dist (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_wa), .i_wdata(d_wd),
        .i_raddr(r_j[NB-1:0]), .o_rdata(d_rd)
    );

    logic          ld_run;
    logic [CB-1:0] nclamp;
    assign nclamp = ({24'd0, r_node_count} > MAX_NODES) ? CB'(MAX_NODES) : CB'(r_node_count);
    assign ld_run = (r_state == dpm_pkg::S_IDLE) && q_valid && !r_ovalid
                    && (q_kind == 1'(dpm_pkg::KIND_RUN));
    assign q_ready = (r_state == dpm_pkg::S_IDLE) && q_valid &&
                     ((q_kind == 1'(dpm_pkg::KIND_LOAD)) || !r_ovalid);

    logic in_issue;
    always_comb begin
        n_state  = r_state;
        in_issue = 1'b0;
        mem_ra   = {NB'(0), r_j[NB-1:0]};
        d_we     = 1'b0;
        d_wa     = r_rj;
        d_wd     = {1'b0, mem_rd};
        unique case (r_state)
            dpm_pkg::S_IDLE: begin
                if (ld_run) n_state = (nclamp < CB'(2)) ? dpm_pkg::S_DONE : dpm_pkg::S_INIT;
            end
            dpm_pkg::S_INIT: begin
                in_issue = (r_j < r_n);
                d_we     = r_rv;
                d_wd     = {(r_rj == '0), mem_rd};
                if (!in_issue && !r_rv) n_state = dpm_pkg::S_SCAN;
            end
            dpm_pkg::S_SCAN: begin
                in_issue = (r_j < r_n);
                if (!in_issue && !r_rv) begin
                    // join the picked node
                    d_we    = r_found;
                    d_wa    = r_pick;
                    d_wd    = {1'b1, r_pdist};
                    n_state = r_found ? dpm_pkg::S_RELAX : dpm_pkg::S_DONE;
                end
            end
            dpm_pkg::S_RELAX: begin
                mem_ra   = {r_pick, r_j[NB-1:0]};
                in_issue = (r_j < r_n);
                d_we     = r_rv && !d_in && (d_dist > mem_rd);
                if (!in_issue && !r_rv)
                    n_state = (r_round + CB'(2) == r_n) ? dpm_pkg::S_DONE : dpm_pkg::S_SCAN;
            end
            dpm_pkg::S_DONE: n_state = dpm_pkg::S_IDLE;
            default: n_state = dpm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dpm_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_rv     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rv    <= in_issue;
            r_rj    <= r_j[NB-1:0];
            if (r_state == dpm_pkg::S_DONE) r_ovalid <= 1'b1;
            else if (o_valid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                dpm_pkg::S_IDLE: begin
                    r_n     <= nclamp;
                    r_j     <= '0;
                    r_round <= '0;
                    r_total <= '0;
                end
                dpm_pkg::S_INIT: begin
                    if (in_issue) r_j <= r_j + CB'(1);
                    else if (!r_rv) begin
                        r_j     <= '0;
                        r_found <= 1'b0;
                    end
                end
                dpm_pkg::S_SCAN: begin
                    if (r_rv && !d_in && (!r_found || d_dist < r_pdist)) begin
                        r_found <= 1'b1;
                        r_pick  <= r_rj;
                        r_pdist <= d_dist;
                    end
                    if (in_issue) r_j <= r_j + CB'(1);
                    else if (!r_rv) begin
                        r_j <= '0;
                        if (r_found) begin
                            r_total <= (r_total + 24'(r_pdist) > TMAX) ? TMAX
                                       : r_total + 24'(r_pdist);
                        end
                    end
                end
                dpm_pkg::S_RELAX: begin
                    if (in_issue) r_j <= r_j + CB'(1);
                    else if (!r_rv) begin
                        r_j     <= '0;
                        r_found <= 1'b0;
                        r_round <= r_round + CB'(1);
                    end
                end
                dpm_pkg::S_DONE: begin
                    r_out <= r_total[22:0];
                end
                default: ;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_total_weight = r_out;

`ifndef NO_ASSERTIONS
    a_done_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dpm_pkg::S_DONE |=> o_valid) else $error("result not raised");
    a_no_run_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !(o_valid && i_ready) |=> r_state != dpm_pkg::S_INIT)
        else $error("run started over pending result");
    a_write_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_state == dpm_pkg::S_IDLE) else $error("matrix write mid run");
    a_dist_write_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_we |-> r_state != dpm_pkg::S_IDLE) else $error("distance write while idle");
`endif

endmodule
